// ----- hdl/ssft_pkg.sv -----
`timescale 1ns / 1ps

package ssft_pkg;

  // Fixed field widths of the transfer payloads
  localparam int unsigned SizeW     = 32;
  localparam int unsigned AddrW     = 32;
  localparam int unsigned RidxW     = 8;
  localparam int unsigned FieldPosW = 9;
  localparam int unsigned MinSizeW  = 16;

  localparam logic [MinSizeW-1:0] MinSizeReset = 16'd16;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_FIND   = 2'd1,
    OP_REMOVE = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_SMALL = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_UPD  = 2'b10
  } state_e;

  // Broadcast from the controller to every cell of the chain
  typedef struct packed {
    logic             cmp_en;
    logic [SizeW-1:0] cmp_key;
    logic             ins_en;
    logic             rem_en;
    logic [SizeW-1:0] ins_size;
    logic [AddrW-1:0] ins_addr;
  } cell_ctl_t;

endpackage

// ----- hdl/ssft_in_if.sv -----
`timescale 1ns / 1ps

interface ssft_in_if import ssft_pkg::*; ();
  logic                 valid;
  logic                 ready;
  op_e                  op;
  logic [SizeW-1:0]     region_size;
  logic [AddrW-1:0]     region_address;
  logic [RidxW-1:0]     remove_index;

  modport source (output valid, op, region_size, region_address, remove_index,
                  input ready);
  modport sink   (input valid, op, region_size, region_address, remove_index,
                  output ready);
endinterface

// ----- hdl/ssft_out_if.sv -----
`timescale 1ns / 1ps

interface ssft_out_if import ssft_pkg::*; ();
  logic                 valid;
  logic                 ready;
  status_e              status;
  logic                 found;
  logic [FieldPosW-1:0] position;
  logic [AddrW-1:0]     entry_address;
  logic [FieldPosW-1:0] entry_count;

  modport source (output valid, status, found, position, entry_address, entry_count,
                  input ready);
  modport sink   (input valid, status, found, position, entry_address, entry_count,
                  output ready);
endinterface

// ----- hdl/ssft_cell.sv -----
`timescale 1ns / 1ps

module ssft_cell import ssft_pkg::*; (
  input  logic             clk_i,
  input  cell_ctl_t        ctl_i,
  input  logic             occ_i,
  input  logic             rsel_i,
  input  logic             prev_lt_i,
  input  logic [SizeW-1:0] prev_size_i,
  input  logic [AddrW-1:0] prev_addr_i,
  input  logic [SizeW-1:0] next_size_i,
  input  logic [AddrW-1:0] next_addr_i,
  output logic [SizeW-1:0] size_o,
  output logic [AddrW-1:0] addr_o,
  output logic             lt_o,
  output logic             eq_o
);

  logic [SizeW-1:0] size_q;
  logic [AddrW-1:0] addr_q;
  logic             lt_q;
  logic             eq_q;

  // Compare the held size against the search key
  always_ff @(posedge clk_i) begin
    if (ctl_i.cmp_en) begin
      lt_q <= occ_i && (size_q < ctl_i.cmp_key);
      eq_q <= occ_i && (size_q == ctl_i.cmp_key);
    end
  end

  // Take the new region at the boundary, shift up above it, or shift down on remove
  always_ff @(posedge clk_i) begin
    if (ctl_i.ins_en && !lt_q) begin
      if (prev_lt_i) begin
        size_q <= ctl_i.ins_size;
        addr_q <= ctl_i.ins_addr;
      end else begin
        size_q <= prev_size_i;
        addr_q <= prev_addr_i;
      end
    end else if (ctl_i.rem_en && rsel_i) begin
      size_q <= next_size_i;
      addr_q <= next_addr_i;
    end
  end

  assign size_o = size_q;
  assign addr_o = addr_q;
  assign lt_o   = lt_q;
  assign eq_o   = eq_q;

endmodule

// ----- hdl/size_sorted_free_space_table.sv -----
`timescale 1ns / 1ps

// Size-sorted free-space table. Holds up to CAPACITY regions (size, address) in
// ascending size order in a chain of cells, one entry per cell. Each operation
// has a compare and an update step: at the input transfer every cell compares its
// size against the key; in the update state the cells shift toward or away from
// their neighbors while the result is registered. The update cycle is held while the
// previous result still waits at the output, so a stalled output adds its stall
// cycles to the operation behind it. One operation is handled at a time;
// the input accepts again right after the update cycle, even while the previous
// result still waits at the output. Insert rejects sizes below min_region_size
// (status 2) before checking for a full table (status 1); equal sizes go in front
// of existing ones. Find returns the lowest matching position or the insertion
// point. Remove past the fill count returns status 3. min_region_size must only be
// written while no operation is in flight.
module size_sorted_free_space_table import ssft_pkg::*; #(
  parameter int unsigned CAPACITY = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [MinSizeW-1:0] cfg_wdata_i,
  ssft_in_if.sink             in_ch,
  ssft_out_if.source          out_ch
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned CmpW = (CntW > RidxW) ? CntW : RidxW;

  state_e               state_q, state_d;
  logic [CntW-1:0]      count_q, count_d;
  logic [MinSizeW-1:0]  min_size_q;
  op_e                  op_q;
  logic [SizeW-1:0]     key_q;
  logic [AddrW-1:0]     addr_q;
  logic [RidxW-1:0]     ridx_q;

  logic                 out_valid_q;
  status_e              out_status_q, out_status_d;
  logic                 out_found_q, out_found_d;
  logic [FieldPosW-1:0] out_pos_q, out_pos_d;
  logic [AddrW-1:0]     out_addr_q, out_addr_d;
  logic [FieldPosW-1:0] out_count_q;

  logic                 in_fire;
  logic                 advance;
  logic                 upd_fire;
  logic                 too_small;
  logic                 is_full;
  logic                 ins_ok;
  logic                 rem_ok;
  cell_ctl_t            ctl;

  logic [SizeW-1:0]     cell_size [CAPACITY];
  logic [AddrW-1:0]     cell_addr [CAPACITY];
  logic [CAPACITY-1:0]  lt;
  logic [CAPACITY-1:0]  eq;
  logic [CAPACITY-1:0]  bnd;
  logic [CntW-1:0]      pos_enc;
  logic                 hit;
  logic [AddrW-1:0]     hit_addr;

  assign in_ch.ready = (state_q == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign advance     = !out_valid_q || out_ch.ready;
  assign upd_fire    = (state_q == S_UPD) && advance;

  // Decode the held operation
  assign too_small = key_q < {{(SizeW - MinSizeW){1'b0}}, min_size_q};
  assign is_full   = count_q == CntW'(CAPACITY);
  assign ins_ok    = (op_q == OP_INSERT) && !too_small && !is_full;
  assign rem_ok    = (op_q == OP_REMOVE) && (CmpW'(ridx_q) < CmpW'(count_q));

  always_comb begin
    ctl          = '0;
    ctl.cmp_en   = in_fire;
    ctl.cmp_key  = in_ch.region_size;
    ctl.ins_en   = upd_fire && ins_ok;
    ctl.rem_en   = upd_fire && rem_ok;
    ctl.ins_size = key_q;
    ctl.ins_addr = addr_q;
  end

  // Cell chain
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic             prev_lt;
    logic [SizeW-1:0] prev_size;
    logic [AddrW-1:0] prev_addr;
    logic [SizeW-1:0] next_size;
    logic [AddrW-1:0] next_addr;

    if (i == 0) begin : g_first
      assign prev_lt   = 1'b1;
      assign prev_size = key_q;
      assign prev_addr = addr_q;
      assign bnd[i]    = !lt[i];
    end else begin : g_mid
      assign prev_lt   = lt[i-1];
      assign prev_size = cell_size[i-1];
      assign prev_addr = cell_addr[i-1];
      assign bnd[i]    = !lt[i] && lt[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign next_size = cell_size[i];
      assign next_addr = cell_addr[i];
    end else begin : g_inner
      assign next_size = cell_size[i+1];
      assign next_addr = cell_addr[i+1];
    end

    ssft_cell u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl),
      .occ_i       (CntW'(i) < count_q),
      .rsel_i      (CmpW'(ridx_q) <= CmpW'(i)),
      .prev_lt_i   (prev_lt),
      .prev_size_i (prev_size),
      .prev_addr_i (prev_addr),
      .next_size_i (next_size),
      .next_addr_i (next_addr),
      .size_o      (cell_size[i]),
      .addr_o      (cell_addr[i]),
      .lt_o        (lt[i]),
      .eq_o        (eq[i])
    );
  end

  // Encode the boundary cell into position, match flag and address
  always_comb begin
    pos_enc  = '0;
    hit      = 1'b0;
    hit_addr = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (bnd[i]) begin
        pos_enc  = pos_enc | CntW'(i);
        hit      = hit | eq[i];
        hit_addr = hit_addr | (eq[i] ? cell_addr[i] : '0);
      end
    end
    if (lt[CAPACITY-1]) begin
      pos_enc = CntW'(CAPACITY);
    end
  end

  // Form the result and the next fill count
  always_comb begin
    out_status_d = ST_OK;
    out_found_d  = 1'b0;
    out_pos_d    = '0;
    out_addr_d   = '0;
    count_d      = count_q;
    unique case (op_q)
      OP_INSERT: begin
        if (too_small) begin
          out_status_d = ST_SMALL;
        end else if (is_full) begin
          out_status_d = ST_FULL;
        end else begin
          out_pos_d = FieldPosW'(pos_enc);
          count_d   = count_q + CntW'(1);
        end
      end
      OP_FIND: begin
        out_found_d = hit;
        out_pos_d   = FieldPosW'(pos_enc);
        out_addr_d  = hit_addr;
      end
      OP_REMOVE: begin
        out_pos_d = FieldPosW'(ridx_q);
        if (rem_ok) begin
          count_d = count_q - CntW'(1);
        end else begin
          out_status_d = ST_RANGE;
        end
      end
      default: begin
        out_status_d = ST_OK;
      end
    endcase
  end

  // Sequence compare and update
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_fire) state_d = S_UPD;
      S_UPD:  if (advance) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      min_size_q  <= MinSizeReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        min_size_q <= cfg_wdata_i;
      end
      if (upd_fire) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold the accepted item
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q   <= in_ch.op;
      key_q  <= in_ch.region_size;
      addr_q <= in_ch.region_address;
      ridx_q <= in_ch.remove_index;
    end
  end

  // Hold the result until its transfer
  always_ff @(posedge clk_i) begin
    if (upd_fire) begin
      out_status_q <= out_status_d;
      out_found_q  <= out_found_d;
      out_pos_q    <= out_pos_d;
      out_addr_q   <= out_addr_d;
      out_count_q  <= FieldPosW'(count_d);
    end
  end

  assign out_ch.valid         = out_valid_q;
  assign out_ch.status        = out_status_q;
  assign out_ch.found         = out_found_q;
  assign out_ch.position      = out_pos_q;
  assign out_ch.entry_address = out_addr_q;
  assign out_ch.entry_count   = out_count_q;

  // Fill count stays within capacity
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CAPACITY))
    else $error("fill count above capacity");

  // Sorted chain gives at most one boundary cell
  a_one_boundary: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPD) |-> $onehot0(bnd))
    else $error("compare flags not monotonic");

  // Accepted insert grows the table by one
  a_insert_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upd_fire && ins_ok) |=> (count_q == $past(count_q) + CntW'(1)))
    else $error("insert did not advance fill count");

  // A result only appears after an update cycle
  a_result_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_UPD))
    else $error("result without update cycle");

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps

module testbench import ssft_pkg::*;;

  localparam int unsigned TableDepth = 256;
  localparam int unsigned QuietLimit = 4000;
  localparam int unsigned HoldCycles = 300;

  typedef struct packed {
    status_e              status;
    logic                 found;
    logic [FieldPosW-1:0] position;
    logic [AddrW-1:0]     entry_address;
    logic [FieldPosW-1:0] entry_count;
  } table_reply_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [MinSizeW-1:0] cfg_wdata_i;

  ssft_in_if  in_ch ();
  ssft_out_if out_ch ();

  size_sorted_free_space_table #(
    .CAPACITY(TableDepth)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_ch      (in_ch),
    .out_ch     (out_ch)
  );

  // Shadow copy of the table, updated at each input transfer
  logic [SizeW-1:0]    shadow_size [TableDepth];
  logic [AddrW-1:0]    shadow_addr [TableDepth];
  int unsigned         shadow_count;
  logic [MinSizeW-1:0] shadow_min;

  table_reply_t expected_replies [$];
  int unsigned  mismatches;
  int unsigned  burst_left;
  int unsigned  quiet_cycles;
  int unsigned  hold_left;
  int unsigned  rx_phase;
  logic         hold_request;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Lowest position whose size is not below the key
  function automatic int unsigned first_not_below(logic [SizeW-1:0] key);
    int unsigned p;
    p = 0;
    while (p < shadow_count && shadow_size[p] < key) p++;
    return p;
  endfunction

  // Apply one operation to the shadow table and return the reply it implies
  function automatic table_reply_t apply_to_shadow(op_e op, logic [SizeW-1:0] sz,
                                                   logic [AddrW-1:0] ad,
                                                   logic [RidxW-1:0] ri);
    table_reply_t r;
    int unsigned  p;
    int unsigned  i;
    r = '0;
    r.status = ST_OK;
    case (op)
      OP_INSERT: begin
        if (sz < {16'h0, shadow_min}) begin
          r.status = ST_SMALL;
        end else if (shadow_count >= TableDepth) begin
          r.status = ST_FULL;
        end else begin
          p = first_not_below(sz);
          for (i = shadow_count; i > p; i--) begin
            shadow_size[i] = shadow_size[i-1];
            shadow_addr[i] = shadow_addr[i-1];
          end
          shadow_size[p] = sz;
          shadow_addr[p] = ad;
          shadow_count++;
          r.position = p[FieldPosW-1:0];
        end
      end
      OP_FIND: begin
        p = first_not_below(sz);
        r.position = p[FieldPosW-1:0];
        if (p < shadow_count && shadow_size[p] == sz) begin
          r.found = 1'b1;
          r.entry_address = shadow_addr[p];
        end
      end
      OP_REMOVE: begin
        r.position = {1'b0, ri};
        if (ri >= shadow_count) begin
          r.status = ST_RANGE;
        end else begin
          for (i = ri; i + 1 < shadow_count; i++) begin
            shadow_size[i] = shadow_size[i+1];
            shadow_addr[i] = shadow_addr[i+1];
          end
          shadow_count--;
        end
      end
      default: ;
    endcase
    r.entry_count = shadow_count[FieldPosW-1:0];
    return r;
  endfunction

  function automatic void compare_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected 0x%0h, actual 0x%0h", $time, field, want, got);
      mismatches++;
    end
  endfunction

  function automatic void check_reply();
    table_reply_t want;
    if (expected_replies.size() == 0) begin
      $display("%0t: reply with nothing pending, expected none, actual status %0d count %0d",
               $time, out_ch.status, out_ch.entry_count);
      mismatches++;
    end else begin
      want = expected_replies.pop_front();
      compare_field("status", 32'(want.status), 32'(out_ch.status));
      compare_field("found", 32'(want.found), 32'(out_ch.found));
      compare_field("position", 32'(want.position), 32'(out_ch.position));
      compare_field("entry_address", want.entry_address, out_ch.entry_address);
      compare_field("entry_count", 32'(want.entry_count), 32'(out_ch.entry_count));
    end
  endfunction

  // Receiver: check each transfer, then stall on a rotating pattern
  always @(posedge clk_i) begin
    if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) check_reply();
    if (hold_request) begin
      hold_left = HoldCycles;
      hold_request = 1'b0;
    end
    rx_phase++;
    if (hold_left != 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      case (rx_phase[8:6])
        3'd0, 3'd4: out_ch.ready <= 1'b1;
        3'd1:       out_ch.ready <= $urandom_range(0, 1) == 0;
        3'd2:       out_ch.ready <= rx_phase[1:0] == 2'd0;
        3'd3:       out_ch.ready <= $urandom_range(0, 3) != 0;
        3'd5:       out_ch.ready <= rx_phase[3];
        3'd6:       out_ch.ready <= $urandom_range(0, 3) == 0;
        default:    out_ch.ready <= rx_phase[1:0] != 2'd0;
      endcase
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("%0t: no transfer for %0d cycles, %0d replies pending", $time,
                 quiet_cycles, expected_replies.size());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Offer one request, with a random gap at the start of each burst
  task automatic issue_request(op_e op, logic [SizeW-1:0] sz, logic [AddrW-1:0] ad,
                               logic [RidxW-1:0] ri);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 2) == 0) ? 0 :
            ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 5);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    in_ch.valid          <= 1'b1;
    in_ch.op             <= op;
    in_ch.region_size    <= sz;
    in_ch.region_address <= ad;
    in_ch.remove_index   <= ri;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    expected_replies.push_back(apply_to_shadow(op, sz, ad, ri));
    burst_left--;
  endtask

  // Drop valid and wait for every pending reply
  task automatic wait_for_replies();
    if (in_ch.valid) in_ch.valid <= 1'b0;
    burst_left = 0;
    while (expected_replies.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_min_size(logic [MinSizeW-1:0] value);
    wait_for_replies();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    shadow_min = value;
    cfg_we_i <= 1'b0;
  endtask

  // Sizes biased toward held entries, the minimum and the extremes
  function automatic logic [SizeW-1:0] pick_size();
    int near;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        if (shadow_count != 0) return shadow_size[$urandom_range(0, shadow_count - 1)];
        return $urandom;
      end
      4, 5: begin
        near = int'(shadow_min) + int'($urandom_range(0, 40)) - 20;
        if (near < 0) near = 0;
        return near;
      end
      6, 7: return $urandom;
      8:    return $urandom_range(0, 255);
      default: begin
        case ($urandom_range(0, 3))
          0:       return '0;
          1:       return '1;
          2:       return {16'h0, shadow_min};
          default: return {16'h0, shadow_min} - 1;
        endcase
      end
    endcase
  endfunction

  // Mostly valid positions, some past the fill count
  function automatic logic [RidxW-1:0] pick_index();
    if (shadow_count == 0) return RidxW'($urandom_range(0, 255));
    if (shadow_count < TableDepth && $urandom_range(0, 4) == 0)
      return RidxW'($urandom_range(shadow_count, 255));
    return RidxW'($urandom_range(0, shadow_count - 1));
  endfunction

  task automatic issue_random_op();
    int unsigned choice;
    choice = $urandom_range(0, 19);
    if (choice < 7)       issue_request(OP_INSERT, pick_size(), $urandom, RidxW'($urandom));
    else if (choice < 13) issue_request(OP_FIND, pick_size(), $urandom, RidxW'($urandom));
    else if (choice < 19) issue_request(OP_REMOVE, $urandom, $urandom, pick_index());
    else                  issue_request(OP_NONE, $urandom, $urandom, RidxW'($urandom));
  endtask

  // Empty table, rejects, ordering of equal sizes, bad indexes, unused op
  task automatic test_directed();
    issue_request(OP_FIND, 32'h0, 32'h0, 8'h0);
    issue_request(OP_REMOVE, 32'h0, 32'h0, 8'h00);
    issue_request(OP_REMOVE, 32'h0, 32'h0, 8'hFF);
    issue_request(OP_INSERT, 32'd15, 32'h1, 8'h0);
    issue_request(OP_INSERT, 32'd0, 32'h2, 8'h0);
    issue_request(OP_INSERT, 32'd16, 32'h0000_0000, 8'h0);
    issue_request(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'h0);
    issue_request(OP_INSERT, 32'd100, 32'h1234_5678, 8'h0);
    issue_request(OP_INSERT, 32'd100, 32'hA5A5_5A5A, 8'h0);
    issue_request(OP_FIND, 32'd100, 32'h0, 8'h0);
    issue_request(OP_FIND, 32'd50, 32'h0, 8'h0);
    issue_request(OP_FIND, 32'hFFFF_FFFF, 32'h0, 8'h0);
    issue_request(OP_FIND, 32'hFFFF_FFFE, 32'h0, 8'h0);
    issue_request(OP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
    issue_request(OP_REMOVE, 32'h0, 32'h0, 8'd4);
    issue_request(OP_REMOVE, 32'h0, 32'h0, 8'd1);
    issue_request(OP_FIND, 32'd100, 32'h0, 8'h0);
    issue_request(OP_REMOVE, 32'h0, 32'h0, 8'd0);
    issue_request(OP_REMOVE, 32'h0, 32'h0, 8'd1);
  endtask

  // Minimum size of one and at the top of its range
  task automatic test_min_size_limits();
    write_min_size(16'd1);
    issue_request(OP_INSERT, 32'd0, 32'hDEAD_0000, 8'h0);
    issue_request(OP_INSERT, 32'd1, 32'hDEAD_0001, 8'h0);
    write_min_size(16'hFFFF);
    issue_request(OP_INSERT, 32'd65534, 32'hBEEF_0000, 8'h0);
    issue_request(OP_INSERT, 32'd65535, 32'hBEEF_0001, 8'h0);
    issue_request(OP_FIND, 32'd65535, 32'h0, 8'h0);
  endtask

  // Fill to capacity, then hit the full table and the small check ahead of it
  task automatic test_fill_to_capacity();
    logic [SizeW-1:0] sz;
    write_min_size(16'd200);
    while (shadow_count < TableDepth) begin
      case ($urandom_range(0, 3))
        0:       sz = pick_size();
        1:       sz = shadow_size[$urandom_range(0, shadow_count - 1)];
        default: sz = $urandom | 32'h0001_0000;
      endcase
      issue_request(OP_INSERT, sz, $urandom, RidxW'($urandom));
    end
    repeat (4) begin
      issue_request(OP_INSERT, $urandom | 32'h0001_0000, $urandom, RidxW'($urandom));
    end
    issue_request(OP_INSERT, 32'd10, $urandom, RidxW'($urandom));
    issue_request(OP_FIND, pick_size(), $urandom, RidxW'($urandom));
    issue_request(OP_REMOVE, $urandom, $urandom, 8'd255);
    issue_request(OP_INSERT, 32'hFFFF_FFFF, $urandom, RidxW'($urandom));
    issue_request(OP_FIND, 32'hFFFF_FFFF, $urandom, RidxW'($urandom));
  endtask

  // Hold the output off while requests keep coming
  task automatic test_output_backpressure();
    hold_request = 1'b1;
    repeat (24) issue_random_op();
  endtask

  task automatic test_random_traffic(int unsigned n_items, logic [MinSizeW-1:0] min_size);
    write_min_size(min_size);
    repeat (n_items) issue_random_op();
  endtask

  initial begin
    rst_ni               = 1'b0;
    cfg_we_i             = 1'b0;
    cfg_wdata_i          = '0;
    in_ch.valid          = 1'b0;
    in_ch.op             = OP_NONE;
    in_ch.region_size    = '0;
    in_ch.region_address = '0;
    in_ch.remove_index   = '0;
    out_ch.ready         = 1'b0;
    shadow_count         = 0;
    shadow_min           = MinSizeReset;
    mismatches           = 0;
    burst_left           = 0;
    quiet_cycles         = 0;
    hold_left            = 0;
    rx_phase             = 0;
    hold_request         = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_min_size_limits();
    test_fill_to_capacity();
    test_output_backpressure();
    test_random_traffic(140, 16'd300);
    test_random_traffic(100, 16'd1);

    wait_for_replies();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- size_sorted_free_space_table.f -----
hdl/ssft_pkg.sv
hdl/ssft_in_if.sv
hdl/ssft_out_if.sv
hdl/ssft_cell.sv
hdl/size_sorted_free_space_table.sv
dv/testbench.sv
